@@ hdl/orlog_pkg.sv @@
`timescale 1ns / 1ps

package orlog_pkg;

    localparam int CAPACITY   = 256;
    localparam int ENTRY_BITS = 64;
    localparam int MAX_RUN    = 64;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam int SKIP_W  = 9;
    localparam int XW      = ((COUNT_W > SKIP_W) ? COUNT_W : SKIP_W) + 1;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] entry_word;
        logic [6:0]  max_entries;
        logic [8:0]  skip_newest;
    } t_in_item;

    typedef struct packed {
        logic [63:0] entry_out;
        logic [7:0]  age_position;
        logic [8:0]  fill_count;
        logic        status;
        logic        last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

endpackage

@@ hdl/orlog_ram.sv @@
`timescale 1ns / 1ps

module orlog_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/overwrite_ring_log_newest_first.sv @@
`timescale 1ns / 1ps

// History ring of CAPACITY entry words that overwrites the oldest entry once full.
// Append and clear each return a single result; a read delivers one entry per
// cycle, newest first, while the output is taken. The entry memory, read one word
// per cycle through a registered read port, sets the read rate. A new command is
// accepted once the previous one has placed its last result in the output register.

module overwrite_ring_log_newest_first (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  orlog_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output orlog_pkg::t_out_item o_out_data
);

    import orlog_pkg::*;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [COUNT_W-1:0] r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic              r_pend, n_pend;
    logic [RUN_W-1:0]  r_left, n_left;
    logic [RUN_W-1:0]  r_out_left, n_out_left;
    t_in_item          r_in, n_in;
    t_out_item         r_out, n_out;
    logic [ADDR_W-1:0] r_raddr, n_raddr;
    logic [ADDR_W-1:0] r_age, n_age;

    logic                  ram_we;
    logic                  ram_re;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic                  can_out;
    logic                  take;
    logic                  issue;
    logic [RUN_W-1:0]      cap_max;
    logic [XW-1:0]         skip_x;
    logic [XW-1:0]         count_x;
    logic [XW-1:0]         head_x;
    logic [XW-1:0]         skip_p1;
    logic [XW-1:0]         avail;
    logic [XW-1:0]         start_x;
    logic                  empty_read;

    orlog_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(ENTRY_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_head),
        .i_wdata(ENTRY_BITS'(r_in.entry_word)),
        .i_re   (ram_re),
        .i_raddr(r_raddr),
        .o_rdata(ram_rdata)
    );

    assign can_out = !r_out_valid || i_out_ready;
    assign take    = (r_state == S_READ) && r_pend && can_out;
    assign issue   = (r_state == S_READ) && (r_left != '0) && (!r_pend || can_out);
    assign ram_re  = issue;

    assign cap_max = (r_in.max_entries > 7'(MAX_RUN)) ? RUN_W'(MAX_RUN)
                                                      : RUN_W'(r_in.max_entries);
    assign skip_x  = XW'(r_in.skip_newest);
    assign count_x = XW'(r_count);
    assign head_x  = XW'(r_head);
    assign skip_p1 = skip_x + XW'(1);
    assign avail   = count_x - skip_x;
    assign start_x = (head_x >= skip_p1) ? (head_x - skip_p1)
                                         : (head_x + XW'(CAPACITY) - skip_p1);
    assign empty_read = (cap_max == '0) || (r_count == '0) || (skip_x >= count_x);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_pend      = r_pend;
        n_left      = r_left;
        n_out_left  = r_out_left;
        n_in        = r_in;
        n_out       = r_out;
        n_raddr     = r_raddr;
        n_age       = r_age;
        ram_we      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_in.command)
                    CMD_APPEND: begin
                        if (can_out) begin
                            ram_we  = 1'b1;
                            n_head  = (r_head == ADDR_W'(CAPACITY - 1)) ? '0
                                                                         : r_head + 1'b1;
                            n_count = (r_count < COUNT_W'(CAPACITY)) ? r_count + 1'b1
                                                                     : r_count;
                            n_out       = '0;
                            n_out.fill_count  = 9'(n_count);
                            n_out.last_of_run = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    CMD_CLEAR: begin
                        if (can_out) begin
                            n_head      = '0;
                            n_count     = '0;
                            n_out       = '0;
                            n_out.last_of_run = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    CMD_READ: begin
                        if (empty_read) begin
                            if (can_out) begin
                                n_out       = '0;
                                n_out.fill_count  = 9'(r_count);
                                n_out.status      = 1'b1;
                                n_out.last_of_run = 1'b1;
                                n_out_valid = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end else begin
                            n_left     = (avail > XW'(cap_max)) ? cap_max : RUN_W'(avail);
                            n_out_left = (avail > XW'(cap_max)) ? cap_max : RUN_W'(avail);
                            n_raddr    = ADDR_W'(start_x);
                            n_age      = ADDR_W'(r_in.skip_newest);
                            n_pend     = 1'b0;
                            n_state    = S_READ;
                        end
                    end
                    default: begin
                        if (can_out) begin
                            n_out       = '0;
                            n_out.fill_count  = 9'(r_count);
                            n_out.last_of_run = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ: begin
                if (take) begin
                    n_out.entry_out    = 64'(ram_rdata);
                    n_out.age_position = 8'(r_age);
                    n_out.fill_count   = 9'(r_count);
                    n_out.status       = 1'b0;
                    n_out.last_of_run  = (r_out_left == RUN_W'(1));
                    n_out_valid        = 1'b1;
                    n_age              = r_age + 1'b1;
                    n_out_left         = r_out_left - 1'b1;
                    if (r_out_left == RUN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
                if (issue) begin
                    n_raddr = (r_raddr == '0) ? ADDR_W'(CAPACITY - 1) : r_raddr - 1'b1;
                    n_left  = r_left - 1'b1;
                    n_pend  = 1'b1;
                end else if (take) begin
                    n_pend = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_out_left  <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_left      <= n_left;
            r_out_left  <= n_out_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_out   <= n_out;
        r_raddr <= n_raddr;
        r_age   <= n_age;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_pend_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_READ))
        else $error("pending read data outside read state");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("memory write and read in same cycle");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left <= r_out_left))
        else $error("more reads issued than results delivered");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |->
            (o_out_data.entry_out == '0 && o_out_data.last_of_run))
        else $error("empty read result carries data");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import orlog_pkg::*;

    localparam logic [1:0]  CMD_RESERVED = 2'd3;
    localparam logic [63:0] WORD_MASK    = ~64'd0 >> (64 - ENTRY_BITS);

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    logic [63:0] shadow_words [CAPACITY];
    int          shadow_head = 0;
    int          shadow_fill = 0;
    t_out_item   ring_replies [$];

    int errors     = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    always #4 i_clk = ~i_clk;

    overwrite_ring_log_newest_first i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    function automatic t_out_item reply(logic [63:0] word, int age, logic status, logic last);
        t_out_item r;
        r.entry_out    = word;
        r.age_position = age[7:0];
        r.fill_count   = shadow_fill[8:0];
        r.status       = status;
        r.last_of_run  = last;
        return r;
    endfunction

    function automatic void ring_outcome(t_in_item item);
        int run_cap;
        int run;
        int skip;
        int slot;
        skip = int'(item.skip_newest);
        case (item.command)
            CMD_APPEND: begin
                shadow_words[shadow_head] = item.entry_word & WORD_MASK;
                shadow_head = (shadow_head + 1) % CAPACITY;
                if (shadow_fill < CAPACITY)
                    shadow_fill++;
                ring_replies.push_back(reply(64'd0, 0, 1'b0, 1'b1));
            end
            CMD_CLEAR: begin
                shadow_head = 0;
                shadow_fill = 0;
                ring_replies.push_back(reply(64'd0, 0, 1'b0, 1'b1));
            end
            CMD_READ: begin
                run_cap = (int'(item.max_entries) > MAX_RUN) ? MAX_RUN : int'(item.max_entries);
                if (run_cap == 0 || shadow_fill == 0 || skip >= shadow_fill) begin
                    ring_replies.push_back(reply(64'd0, 0, 1'b1, 1'b1));
                end else begin
                    run = shadow_fill - skip;
                    if (run > run_cap)
                        run = run_cap;
                    for (int i = 0; i < run; i++) begin
                        slot = (shadow_head + CAPACITY - 1 - skip - i) % CAPACITY;
                        ring_replies.push_back(reply(shadow_words[slot], skip + i, 1'b0,
                                                     i == run - 1));
                    end
                end
            end
            default: begin
                ring_replies.push_back(reply(64'd0, 0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ring_replies.size() == 0) begin
                $error("result with nothing outstanding: %p", o_out_data);
                errors++;
            end else begin
                due = ring_replies.pop_front();
                if (o_out_data.entry_out !== due.entry_out) begin
                    $error("entry_out: expected %h, got %h", due.entry_out,
                           o_out_data.entry_out);
                    errors++;
                end
                if (o_out_data.age_position !== due.age_position) begin
                    $error("age_position: expected %0d, got %0d", due.age_position,
                           o_out_data.age_position);
                    errors++;
                end
                if (o_out_data.fill_count !== due.fill_count) begin
                    $error("fill_count: expected %0d, got %0d", due.fill_count,
                           o_out_data.fill_count);
                    errors++;
                end
                if (o_out_data.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.last_of_run !== due.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d", due.last_of_run,
                           o_out_data.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (stall_left % 4 == 0);
        endcase
    end

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    task automatic send_command(t_in_item item);
        pace();
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ring_outcome(item);
    endtask

    // hold off new commands until every outstanding result has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ring_replies.size() != 0);
        burst_left = 0;
    endtask

    function automatic t_in_item make_item(logic [1:0] cmd, logic [63:0] word, int most,
                                           int skip);
        t_in_item item;
        item.command     = cmd;
        item.entry_word  = word;
        item.max_entries = most[6:0];
        item.skip_newest = skip[8:0];
        return item;
    endfunction

    function automatic t_in_item random_read();
        int most;
        int skip;
        int pick;
        pick = $urandom_range(0, 9);
        most = (pick == 0) ? 0 : (pick < 8) ? $urandom_range(1, 12) : $urandom_range(13, 127);
        pick = $urandom_range(0, 9);
        skip = (pick < 7) ? $urandom_range(0, shadow_fill) : $urandom_range(0, 511);
        return make_item(CMD_READ, {$urandom, $urandom}, most, skip);
    endfunction

    task automatic test_empty_ring();
        send_command(make_item(CMD_READ, '1, 1, 0));
        send_command(make_item(CMD_READ, '0, 0, 0));
        send_command(make_item(CMD_CLEAR, '1, 127, 511));
        send_command(make_item(CMD_RESERVED, '1, 127, 511));
    endtask

    task automatic test_field_extremes();
        send_command(make_item(CMD_APPEND, 64'd0, 0, 0));
        send_command(make_item(CMD_APPEND, '1, 127, 511));
        send_command(make_item(CMD_APPEND, 64'h5555_5555_5555_5555, 0, 0));
        send_command(make_item(CMD_APPEND, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0));
        send_command(make_item(CMD_APPEND, {$urandom, $urandom}, 0, 0));
        send_command(make_item(CMD_READ, '0, 0, 0));
        send_command(make_item(CMD_READ, '0, 127, 0));
        send_command(make_item(CMD_READ, '0, 65, 1));
        send_command(make_item(CMD_READ, '0, 64, 0));
        send_command(make_item(CMD_READ, '0, 1, 4));
        send_command(make_item(CMD_READ, '0, 1, 0));
        send_command(make_item(CMD_READ, '0, 2, 3));
        send_command(make_item(CMD_READ, '0, 64, 5));
        send_command(make_item(CMD_READ, '1, 127, 511));
        send_command(make_item(CMD_RESERVED, 64'd7, 3, 0));
        send_command(make_item(CMD_READ, '0, 2, 0));
        send_command(make_item(CMD_CLEAR, '0, 0, 0));
        send_command(make_item(CMD_READ, '0, 64, 0));
        send_command(make_item(CMD_APPEND, 64'h8000_0000_0000_0001, 0, 0));
        send_command(make_item(CMD_READ, '0, 1, 0));
    endtask

    task automatic test_random_mix(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                settle();
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_command(make_item(CMD_APPEND, {$urandom, $urandom},
                                       $urandom_range(0, 127), $urandom_range(0, 511)));
            else if (pick < 85)
                send_command(random_read());
            else if (pick < 89)
                send_command(make_item(CMD_CLEAR, {$urandom, $urandom}, 0, 0));
            else
                send_command(make_item(CMD_RESERVED, {$urandom, $urandom},
                                       $urandom_range(0, 127), $urandom_range(0, 511)));
        end
    endtask

    task automatic test_ring_wrap();
        send_command(make_item(CMD_CLEAR, '0, 0, 0));
        for (int n = 0; n < 260; n++) begin
            send_command(make_item(CMD_APPEND, {$urandom, $urandom}, 0, 0));
            if (n % 26 == 25)
                send_command(random_read());
        end
        send_command(make_item(CMD_READ, '0, 64, 192));
        send_command(make_item(CMD_READ, '0, 127, 255));
        send_command(make_item(CMD_READ, '0, 64, 256));
        send_command(make_item(CMD_READ, '0, 64, 0));
        send_command(make_item(CMD_CLEAR, '0, 0, 0));
        send_command(make_item(CMD_READ, '0, 1, 0));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_ring();
        test_field_extremes();
        test_random_mix(80);
        test_ring_wrap();
        settle();
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #10000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/orlog_pkg.sv
hdl/orlog_ram.sv
hdl/overwrite_ring_log_newest_first.sv
tb/sv/testbench.sv
